/* hw/rtl/packed_pcm_unpacker_with_limit_top_defines.svh */
// Assertion macros for the packed PCM unpacker.
`ifndef PACKED_PCM_UNPACKER_WITH_LIMIT_TOP_DEFINES_SVH
`define PACKED_PCM_UNPACKER_WITH_LIMIT_TOP_DEFINES_SVH

// Same-cycle implication on clock, disabled during reset.
`define PCMU_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication on clock, disabled during reset.
`define PCMU_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/pcmu_pkg.sv */
// Types and constants shared by the packed PCM unpacker modules.
package pcmu_pkg;

   // register indexes on the csr port
   localparam logic [1:0] CSR_WIDE_SAMPLES = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_RATE  = 2'd1;

   // sample rates that raise the frame cap
   localparam logic [23:0] RATE_192K = 24'd192000;
   localparam logic [23:0] RATE_176K = 24'd176400;
   localparam logic [23:0] RATE_96K  = 24'd96000;
   localparam logic [23:0] RATE_88K  = 24'd88200;

   // largest frame count a 10-bit byte length can give
   localparam int FRAMES_MAX = 255;

   // floor(x / 6) == (x * 683) >> 12 for every 10-bit x
   localparam logic [9:0] DIV6_MULT  = 10'd683;
   localparam int         DIV6_SHIFT = 12;

   typedef struct packed {
      logic [31:0] packet_word;
      logic [9:0]  packet_bytes;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic signed [23:0] sample;
      logic               channel;
      logic               item_done;
      logic               packet_done;
   } rsp_type;

   // results produced by one accepted transaction
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } emit_type;

endpackage

/* hw/rtl/pcmu_core.sv */
// Word unpacker: byte carry, phase tracking and frame-cap filtering.
module pcmu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  pcmu_pkg::req_type  req,
   input  logic               wide_samples,
   input  logic [7:0]         frame_cap,
   output pcmu_pkg::emit_type emit
);

   logic [1:0]  phase_ff, phase_in;
   logic [15:0] carried_ff, carried_in;
   logic [9:0]  emitted_ff, emitted_in;

   logic [31:0] w;
   logic [23:0] cand0, cand1;
   logic        has2;
   logic [19:0] div6_prod;
   logic [7:0]  frames_raw, frames;
   logic [9:0]  limit;
   logic [9:0]  e1;
   logic        v0, v1;

   assign w         = req.packet_word;
   assign div6_prod = 20'(req.packet_bytes) * 20'(pcmu_pkg::DIV6_MULT);

   always_comb begin
      phase_in   = phase_ff;
      carried_in = carried_ff;
      cand0      = '0;
      cand1      = '0;
      has2       = 1'b0;
      if (wide_samples) begin
         frames_raw = div6_prod[pcmu_pkg::DIV6_SHIFT +: 8];
         case (phase_ff)
            2'd1: begin
               cand0      = {w[15:0], carried_ff[7:0]};
               carried_in = w[31:16];
               phase_in   = 2'd2;
            end
            2'd2: begin
               cand0      = {w[7:0], carried_ff};
               cand1      = w[31:8];
               has2       = 1'b1;
               carried_in = '0;
               phase_in   = 2'd0;
            end
            default: begin
               // phase three behaves as phase zero
               cand0      = w[23:0];
               carried_in = {8'd0, w[31:24]};
               phase_in   = 2'd1;
            end
         endcase
      end else begin
         frames_raw = req.packet_bytes[9:2];
         cand0      = {w[15:0], 8'd0};
         cand1      = {w[31:16], 8'd0};
         has2       = 1'b1;
         phase_in   = 2'd0;
      end

      frames = (frames_raw > frame_cap) ? frame_cap : frames_raw;
      limit  = {1'b0, frames, 1'b0};

      v0 = emitted_ff < limit;
      e1 = v0 ? 10'(emitted_ff + 10'd1) : emitted_ff;
      v1 = has2 && (e1 < limit);

      emitted_in = 10'(e1 + {9'd0, v1});
      if (req.final_word) begin
         phase_in   = '0;
         carried_in = '0;
         emitted_in = '0;
      end

      emit.count              = accept ? (2'({1'b0, v0}) + 2'({1'b0, v1})) : 2'd0;
      emit.first.sample       = cand0;
      emit.first.channel      = emitted_ff[0];
      emit.first.item_done    = !v1;
      emit.first.packet_done  = 10'(emitted_ff + 10'd1) == limit;
      emit.second.sample      = cand1;
      emit.second.channel     = e1[0];
      emit.second.item_done   = 1'b1;
      emit.second.packet_done = 10'(e1 + 10'd1) == limit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         carried_ff <= '0;
         emitted_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         carried_ff <= carried_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

/* hw/rtl/packed_pcm_unpacker_with_limit_top.sv */
// Top level of the packed PCM unpacker: csr registers, core and result queue.
//
// Usage:
//  - req channel: one little-endian 32-bit packet word per transaction, with the
//    packet length in bytes and a final_word flag on the last word of a packet.
//  - rsp channel: 24-bit signed samples, left and right alternating,
//    with item_done on the last sample of a word and packet_done on the sample
//    that reaches the capped frame count. Samples past the cap are dropped.
//  - csr channel: index 0 = wide_samples, index 1 = sample_rate. Always ready.
//    Write only while no transaction is in flight.
//  - With the result queue empty, a sample is on rsp in the cycle after its
//    word is accepted.
//  - The single rsp port moves one sample per cycle while rsp_stall is low, so
//    words go in at the sample rate: a word gives two samples in 16-bit mode,
//    three words give four in 24-bit mode, and words the cap drops give none.
//  - req_stall is high while three or more samples sit in the four-entry queue,
//    so a stalled rsp side backs up into req after at most two words (16-bit).
//  - Reset (synchronous): csr registers, phase, carry, sample count and queue
//    all clear; rsp_valid drops in the cycle after reset is seen.
`include "packed_pcm_unpacker_with_limit_top_defines.svh"

module packed_pcm_unpacker_with_limit_top #(
   parameter int QUEUE_SIZE = 1024
) (
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_stall,
   input  pcmu_pkg::req_type req_data,
   // samples
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pcmu_pkg::rsp_type rsp_data,
   // configuration
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_data
);

   // frame caps per rate group, clipped to what a packet length can reach
   localparam int CapHighRate = QUEUE_SIZE / 4;
   localparam int CapMidRate  = QUEUE_SIZE / 8;
   localparam int CapLowRate  = QUEUE_SIZE / 16;
   localparam logic [7:0] CapHighSat = (CapHighRate > pcmu_pkg::FRAMES_MAX) ?
                                       8'(pcmu_pkg::FRAMES_MAX) : 8'(CapHighRate);
   localparam logic [7:0] CapMidSat  = (CapMidRate > pcmu_pkg::FRAMES_MAX) ?
                                       8'(pcmu_pkg::FRAMES_MAX) : 8'(CapMidRate);
   localparam logic [7:0] CapLowSat  = (CapLowRate > pcmu_pkg::FRAMES_MAX) ?
                                       8'(pcmu_pkg::FRAMES_MAX) : 8'(CapLowRate);

   // csr registers
   logic        wide_ff;
   logic [23:0] rate_ff;
   logic [7:0]  frame_cap;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff <= 1'b0;
         rate_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            pcmu_pkg::CSR_WIDE_SAMPLES: wide_ff <= csr_data[0];
            pcmu_pkg::CSR_SAMPLE_RATE:  rate_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (rate_ff == pcmu_pkg::RATE_192K || rate_ff == pcmu_pkg::RATE_176K) begin
         frame_cap = CapHighSat;
      end else if (rate_ff == pcmu_pkg::RATE_96K || rate_ff == pcmu_pkg::RATE_88K) begin
         frame_cap = CapMidSat;
      end else begin
         frame_cap = CapLowSat;
      end
   end

   // unpack core
   logic               req_accept;
   pcmu_pkg::emit_type emit;

   assign req_accept = req_valid && !req_stall;

   pcmu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req          (req_data),
      .wide_samples (wide_ff),
      .frame_cap    (frame_cap),
      .emit         (emit)
   );

   // four-entry result queue; up to two writes and one read per cycle
   pcmu_pkg::rsp_type queue_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fifo_count_ff, fifo_count_in;
   logic       pop;

   assign req_stall = fifo_count_ff > 3'd2;
   assign rsp_valid = fifo_count_ff != 3'd0;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      wr_ptr_in     = 2'(wr_ptr_ff + emit.count);
      rd_ptr_in     = 2'(rd_ptr_ff + {1'b0, pop});
      fifo_count_in = 3'(fifo_count_ff + {1'b0, emit.count} - {2'd0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         fifo_count_ff <= fifo_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= emit.first;
      end
      if (emit.count == 2'd2) begin
         queue_ff[2'(wr_ptr_ff + 2'd1)] <= emit.second;
      end
   end

   // checks
   logic       pop_only;
   logic [2:0] count_less_one;
   logic       rsp_packet_end;

   assign pop_only       = pop && (emit.count == 2'd0);
   assign count_less_one = 3'(fifo_count_ff - 3'd1);
   assign rsp_packet_end = rsp_valid && rsp_data.packet_done;

   `PCMU_ASSERT_IMP(a_queue_bound, 1'b1, fifo_count_ff <= 3'd4, "result queue overfilled")
   `PCMU_ASSERT_IMP(a_room_on_accept, req_accept, fifo_count_ff <= 3'd2, "no queue room")
   `PCMU_ASSERT_NXT(a_pop_only, pop_only, fifo_count_ff == $past(count_less_one), "pop count off")
   `PCMU_ASSERT_IMP(a_done_order, rsp_packet_end, rsp_data.item_done, "packet end mid word")

endmodule

/* verif/pcmu_checker.sv */
// Checker for the packed PCM unpacker: predicts samples from observed transactions and compares.
module pcmu_checker #(
   parameter int QUEUE_SIZE = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pcmu_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pcmu_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [23:0]       csr_data,
   output int                errors,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pcmu_pkg::*;

   // predictor copy of the registers and the unpacking state
   logic        wide_mode;
   logic [23:0] rate_hz;
   logic [1:0]  group_phase;
   logic [15:0] carry_bytes;
   logic [9:0]  packet_samples;

   rsp_type expected_samples[$];

   function automatic int frame_cap(input logic [23:0] rate);
      case (rate)
         RATE_192K, RATE_176K: return QUEUE_SIZE / 4;
         RATE_96K, RATE_88K:   return QUEUE_SIZE / 8;
         default:              return QUEUE_SIZE / 16;
      endcase
   endfunction

   // work out the samples one packet word yields and queue them
   task automatic unpack_word(input req_type item);
      logic [23:0] cand [2];
      rsp_type     made [2];
      int          ncand;
      int          nmade;
      int          frames;
      int          limit;
      ncand = 0;
      nmade = 0;
      if (wide_mode) begin
         frames = item.packet_bytes / 6;
         case (group_phase)
            2'd1: begin
               cand[0]     = {item.packet_word[15:0], carry_bytes[7:0]};
               carry_bytes = item.packet_word[31:16];
               group_phase = 2'd2;
               ncand       = 1;
            end
            2'd2: begin
               cand[0]     = {item.packet_word[7:0], carry_bytes};
               cand[1]     = item.packet_word[31:8];
               carry_bytes = 16'd0;
               group_phase = 2'd0;
               ncand       = 2;
            end
            default: begin
               cand[0]     = item.packet_word[23:0];
               carry_bytes = {8'd0, item.packet_word[31:24]};
               group_phase = 2'd1;
               ncand       = 1;
            end
         endcase
      end else begin
         frames      = item.packet_bytes / 4;
         group_phase = 2'd0;
         cand[0]     = {item.packet_word[15:0], 8'd0};
         cand[1]     = {item.packet_word[31:16], 8'd0};
         ncand       = 2;
      end
      if (frames > frame_cap(rate_hz))
         frames = frame_cap(rate_hz);
      limit = frames * 2;
      for (int i = 0; i < ncand; i++) begin
         if (int'(packet_samples) < limit) begin
            made[nmade].sample      = cand[i];
            made[nmade].channel     = packet_samples[0];
            made[nmade].item_done   = 1'b0;
            made[nmade].packet_done = (int'(packet_samples) + 1 == limit);
            packet_samples          = packet_samples + 10'd1;
            nmade++;
         end
      end
      if (nmade > 0)
         made[nmade - 1].item_done = 1'b1;
      for (int i = 0; i < nmade; i++)
         expected_samples.push_back(made[i]);
      if (item.final_word) begin
         group_phase    = 2'd0;
         carry_bytes    = 16'd0;
         packet_samples = 10'd0;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         errors         = 0;
         wide_mode      = 1'b0;
         rate_hz        = 24'd0;
         group_phase    = 2'd0;
         carry_bytes    = 16'd0;
         packet_samples = 10'd0;
         expected_samples.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected sample %0d ch %0d", rsp_data.sample, rsp_data.channel);
               errors++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_data.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d", want.sample, rsp_data.sample);
                  errors++;
               end
               if (rsp_data.channel !== want.channel) begin
                  $error("channel: expected %0d, got %0d", want.channel, rsp_data.channel);
                  errors++;
               end
               if (rsp_data.item_done !== want.item_done) begin
                  $error("item_done: expected %0d, got %0d",
                         want.item_done, rsp_data.item_done);
                  errors++;
               end
               if (rsp_data.packet_done !== want.packet_done) begin
                  $error("packet_done: expected %0d, got %0d",
                         want.packet_done, rsp_data.packet_done);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WIDE_SAMPLES: wide_mode = csr_data[0];
               CSR_SAMPLE_RATE:  rate_hz   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            unpack_word(req_data);
      end
      pending <= expected_samples.size();
   end

endmodule

/* verif/tb.sv */
// Testbench top for the packed PCM unpacker: clock, reset, stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcmu_pkg::*;

   localparam int QUEUE_SIZE    = 1024;
   localparam int NUM_PHASES    = 9;
   localparam int PHASE_WORDS   = 156;   // random words per register setting
   localparam int LONG_HOLD     = 300;   // cycles the sample side holds off
   localparam int SETTLE_CYCLES = 4;     // margin after the queue has drained

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_WIDE_SAMPLES;
   logic [23:0] csr_data  = '0;

   int errors;
   int pending;
   int words_sent = 0;

   // idling is switched off for the closing phase
   bit idle_on          = 1'b1;
   // set by the stimulus, consumed by the sample-side process
   bit hold_off_request = 1'b0;

   // register settings per phase: both modes, every cap class, rate extremes
   logic        phase_wide [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                                            1'b1, 1'b1, 1'b0, 1'b1};
   logic [23:0] phase_rate [NUM_PHASES] = '{24'd0, RATE_192K, RATE_192K, RATE_176K,
                                            RATE_96K, RATE_88K, 24'hFFFFFF,
                                            24'hFFFFFF, 24'd192001};

   packed_pcm_unpacker_with_limit_top #(
      .QUEUE_SIZE(QUEUE_SIZE)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   pcmu_checker #(
      .QUEUE_SIZE(QUEUE_SIZE)
   ) sample_check (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .errors   (errors),
      .pending  (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sample side: random stall bursts, plus a long hold-off on each request so the
   // result queue fills and the block pushes back on the word side.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one word; returns at the edge where the transaction completes.
   // Valid is left high so back-to-back words need no extra edge.
   task automatic send_word(input req_type item);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic send_fields(input logic [31:0] word, input logic [9:0] nbytes,
                              input logic last);
      req_type item;
      item.packet_word  = word;
      item.packet_bytes = nbytes;
      item.final_word   = last;
      send_word(item);
   endtask

   // Stop offering and wait until every predicted sample has come out.
   // pending is registered behind the checker, so poll from the next edge on.
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Registers only change with nothing in flight.
   task automatic apply_setting(input logic wide, input logic [23:0] rate);
      wait_drain();
      write_register(CSR_WIDE_SAMPLES, {23'd0, wide});
      write_register(CSR_SAMPLE_RATE, rate);
      csr_valid <= 1'b0;
   endtask

   // One packet of random words. Most are well formed: a length, the words that
   // length needs, and a final marker on the last. Broken ones run short or long,
   // may miss the final marker or get stray ones, and may change length mid-way.
   task automatic send_packet(input bit broken);
      int      pick;
      int      nbytes;
      int      nwords;
      req_type item;
      pick = $urandom_range(0, 99);
      if (pick < 75)
         nbytes = $urandom_range(0, 96);
      else if (pick < 93)
         nbytes = $urandom_range(97, 400);
      else
         nbytes = $urandom_range(401, 1023);
      nwords = (nbytes + 3) / 4;
      if (nwords == 0)
         nwords = 1;
      if (broken)
         nwords = $urandom_range(1, nwords + 8);
      for (int i = 0; i < nwords; i++) begin
         item.packet_word  = $urandom;
         item.packet_bytes = 10'(nbytes);
         item.final_word   = (i == nwords - 1);
         if (broken) begin
            if ($urandom_range(0, 3) == 0)
               item.packet_bytes = 10'($urandom_range(0, 1023));
            if (i == nwords - 1)
               item.final_word = 1'($urandom_range(0, 1));
            else
               item.final_word = ($urandom_range(0, 15) == 0);
         end
         send_word(item);
      end
   endtask

   initial begin
      int target;
      int npackets;
      int wait_cycles;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed: 16-bit mode, default cap ---
      apply_setting(1'b0, 24'd0);
      // all-zero and all-one words
      send_fields(32'h0000_0000, 10'd8, 1'b0);
      send_fields(32'hFFFF_FFFF, 10'd8, 1'b1);
      // most negative and most positive halves
      send_fields(32'h8000_7FFF, 10'd8, 1'b0);
      send_fields(32'h7FFF_8000, 10'd8, 1'b1);
      // one frame only: the second word is dropped entirely
      send_fields(32'h1234_5678, 10'd4, 1'b0);
      send_fields(32'h9ABC_DEF0, 10'd4, 1'b1);
      // empty packet
      send_fields(32'hDEAD_BEEF, 10'd0, 1'b1);

      // --- directed: 24-bit mode, all three positions in a group ---
      apply_setting(1'b1, 24'd0);
      send_fields(32'h80FF_FFFF, 10'd12, 1'b0);
      send_fields(32'h7F80_0000, 10'd12, 1'b0);
      send_fields(32'hFFFF_FF7F, 10'd12, 1'b1);
      // short packet: a partial frame counts as zero frames
      send_fields(32'hA5A5_A5A5, 10'd5, 1'b0);
      send_fields(32'h5A5A_5A5A, 10'd5, 1'b1);
      // longest length, capped by the default rate
      send_fields(32'h0123_4567, 10'd1023, 1'b0);
      send_fields(32'h89AB_CDEF, 10'd1023, 1'b1);

      // --- directed: mode change in the middle of a group ---
      send_fields(32'hCAFE_F00D, 10'd12, 1'b0);
      apply_setting(1'b0, 24'd0);
      send_fields(32'h1357_9BDF, 10'd12, 1'b0);
      apply_setting(1'b1, 24'd0);
      send_fields(32'h2468_ACE0, 10'd12, 1'b1);

      // --- random phases, one register setting each ---
      target = words_sent;
      for (int p = 0; p < NUM_PHASES; p++) begin
         // the closing phase runs flat out on both sides
         if (p == NUM_PHASES - 1)
            idle_on = 1'b0;
         apply_setting(phase_wide[p], phase_rate[p]);
         if (p == 1 || p == 5)
            hold_off_request = 1'b1;
         target   += PHASE_WORDS;
         npackets  = 0;
         while (words_sent < target) begin
            send_packet($urandom_range(0, 4) == 0);
            npackets++;
            // word side pauses until everything has drained, mid-stream
            if (npackets == 2 && p % 2 == 0)
               wait_drain();
         end
      end

      // --- drain and verdict ---
      req_valid <= 1'b0;
      wait_cycles = 0;
      @(posedge clock);
      while (pending != 0 && wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (pending != 0) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES * 2) @(posedge clock);
         if (errors == 0)
            $display("tb: done, clean");
         else
            $display("tb: done, errors");
         $finish;
      end
   end

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule

/* packed_pcm_unpacker_with_limit_top.f */
+incdir+hw/rtl
hw/rtl/pcmu_pkg.sv
hw/rtl/pcmu_core.sv
hw/rtl/packed_pcm_unpacker_with_limit_top.sv
verif/pcmu_checker.sv
verif/tb.sv
